// ===== design/ptts_pkg.sv =====
// ptts_pkg: shared types and constants for the periodic task tick scheduler.
// No dependencies.

package ptts_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CREATE  = 3'd1;
    localparam logic [2:0] OP_SUSPEND = 3'd2;
    localparam logic [2:0] OP_RESUME  = 3'd3;
    localparam logic [2:0] OP_DELETE  = 3'd4;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  slot;
        logic [15:0] period;
        logic [15:0] first_delay;
    } t_req;

    typedef struct packed {
        logic [2:0] task_slot;
        logic       task_due;
        logic       create_failed;
        logic       last_of_run;
    } t_rsp;

    typedef struct packed {
        logic rd_en;
        logic cd_we;
        logic rl_we;
    } t_mem_cmd;

    typedef struct packed {
        logic        due;
        logic        wr_en;
        logic [15:0] cd_next;
    } t_alu_res;

endpackage

// ===== design/ptts_mem.sv =====
// ptts_mem: countdown and reload-period slot memories, registered read.
// Countdown entries read as zero until first written. Uses ptts_pkg.

module ptts_mem #(
    parameter int NUM_SLOTS = 8,
    parameter int IW        = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptts_pkg::t_mem_cmd i_cmd,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [15:0]       i_cd_wdata,
    input  logic [15:0]       i_rl_wdata,
    input  logic [IW-1:0]     i_rd_addr,
    output logic [15:0]       o_cd_rdata,
    output logic [15:0]       o_rl_rdata
);

    logic [15:0]          r_cd_mem [NUM_SLOTS];
    logic [15:0]          r_rl_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_cd_vld;
    logic                 r_rd_vld;
    logic [15:0]          r_cd_q;
    logic [15:0]          r_rl_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cd_we) begin
            r_cd_mem[i_wr_addr] <= i_cd_wdata;
        end
        if (i_cmd.rl_we) begin
            r_rl_mem[i_wr_addr] <= i_rl_wdata;
        end
        if (i_cmd.rd_en) begin
            r_cd_q <= r_cd_mem[i_rd_addr];
            r_rl_q <= r_rl_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_vld <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.cd_we) begin
                r_cd_vld[i_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_cd_vld[i_rd_addr];
            end
        end
    end

    assign o_cd_rdata = r_rd_vld ? r_cd_q : 16'd0;
    assign o_rl_rdata = r_rl_q;

endmodule

// ===== design/ptts_alu.sv =====
// ptts_alu: shared 16-bit decrement unit for one slot visit per cycle.
// Picks countdown or reload period, subtracts one, flags due. Uses ptts_pkg.

module ptts_alu (
    input  logic               i_active,
    input  logic               i_occupied,
    input  logic [15:0]        i_countdown,
    input  logic [15:0]        i_reload,
    output ptts_pkg::t_alu_res o_res
);

    logic        w_zero;
    logic [15:0] w_operand;

    assign w_zero    = (i_countdown == 16'd0);
    assign w_operand = w_zero ? i_reload : i_countdown;

    assign o_res.cd_next = w_operand - 16'd1;
    assign o_res.due     = i_active & w_zero & i_occupied;
    // empty slot parked at zero keeps its value
    assign o_res.wr_en   = i_active & (~w_zero | i_occupied);

endmodule

// ===== design/periodic_task_tick_scheduler_core.sv =====
// periodic_task_tick_scheduler_core: slot table sequencer, one slot per cycle.
// Create/suspend/resume/delete give their result in the cycle after the request.
// Tick: busy for the slot walk through the single memory read
// port and shared decrement unit; results stream out, the last in the same cycle busy drops.
// Throughput: one non-tick request per cycle while idle; none is taken while busy.
// Reset (sync, active low) empties and suspends all slots and zeroes countdowns.

module periodic_task_tick_scheduler_core #(
    parameter int NUM_SLOTS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ptts_pkg::t_req i_req,
    output logic           o_rsp_valid,
    output ptts_pkg::t_rsp o_rsp
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic                     r_state, n_state;
    logic [NUM_SLOTS-1:0]     r_occ, n_occ;
    logic [NUM_SLOTS-1:0]     r_act, n_act;
    logic [CW-1:0]            r_rd_idx, n_rd_idx;
    logic                     r_pv, n_pv;
    logic [IW-1:0]            r_p_idx, n_p_idx;
    logic [ptts_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                     r_pend, n_pend;
    logic [2:0]               r_pend_slot, n_pend_slot;
    logic                     r_out_valid, n_out_valid;
    ptts_pkg::t_rsp           r_out, n_out;

    logic [IW-1:0]            w_slot_idx;
    logic                     w_in_range;
    logic                     w_fail;
    ptts_pkg::t_mem_cmd       w_cmd;
    logic [IW-1:0]            w_wr_addr;
    logic [15:0]              w_cd_wdata;
    logic [15:0]              w_cd_rdata;
    logic [15:0]              w_rl_rdata;
    ptts_pkg::t_alu_res       w_alu;

    assign w_slot_idx = IW'(i_req.slot);
    assign w_in_range = (int'(i_req.slot) < NUM_SLOTS);

    ptts_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_wr_addr  (w_wr_addr),
        .i_cd_wdata (w_cd_wdata),
        .i_rl_wdata (i_req.period),
        .i_rd_addr  (r_rd_idx[IW-1:0]),
        .o_cd_rdata (w_cd_rdata),
        .o_rl_rdata (w_rl_rdata)
    );

    ptts_alu u_alu (
        .i_active    (r_act[r_p_idx]),
        .i_occupied  (r_occ[r_p_idx]),
        .i_countdown (w_cd_rdata),
        .i_reload    (w_rl_rdata),
        .o_res       (w_alu)
    );

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_act       = r_act;
        n_rd_idx    = r_rd_idx;
        n_pv        = r_pv;
        n_p_idx     = r_p_idx;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_out_valid = 1'b0;
        n_out       = r_out;
        w_fail      = 1'b0;
        w_cmd       = '0;
        w_wr_addr   = w_slot_idx;
        w_cd_wdata  = i_req.first_delay;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req.opcode == ptts_pkg::OP_TICK) begin
                        n_state  = ST_TICK;
                        n_rd_idx = '0;
                        n_pv     = 1'b0;
                        n_cnt    = '0;
                        n_pend   = 1'b0;
                    end else begin
                        case (i_req.opcode)
                            ptts_pkg::OP_CREATE: begin
                                if (!w_in_range || r_occ[w_slot_idx]) begin
                                    w_fail = 1'b1;
                                end else begin
                                    n_occ[w_slot_idx] = 1'b1;
                                    n_act[w_slot_idx] = 1'b1;
                                    w_cmd.cd_we       = 1'b1;
                                    w_cmd.rl_we       = 1'b1;
                                end
                            end
                            ptts_pkg::OP_SUSPEND: begin
                                if (w_in_range) begin
                                    n_act[w_slot_idx] = 1'b0;
                                end
                            end
                            ptts_pkg::OP_RESUME: begin
                                if (w_in_range) begin
                                    n_act[w_slot_idx] = 1'b1;
                                end
                            end
                            ptts_pkg::OP_DELETE: begin
                                if (w_in_range) begin
                                    n_occ[w_slot_idx] = 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                        n_out_valid = 1'b1;
                        n_out = '{task_slot: i_req.slot, task_due: 1'b0,
                                  create_failed: w_fail, last_of_run: 1'b1};
                    end
                end
            end
            ST_TICK: begin
                n_pv = 1'b0;
                if (r_rd_idx < CW'(NUM_SLOTS)) begin
                    w_cmd.rd_en = 1'b1;
                    n_rd_idx    = r_rd_idx + 1'b1;
                    n_pv        = 1'b1;
                    n_p_idx     = r_rd_idx[IW-1:0];
                end
                if (r_pv) begin
                    w_cmd.cd_we = w_alu.wr_en;
                    w_wr_addr   = r_p_idx;
                    w_cd_wdata  = w_alu.cd_next;
                    // hold each due slot until the next one shows it is not last
                    if (w_alu.due && (int'(r_cnt) < ptts_pkg::MAX_RESULTS)) begin
                        if (r_pend) begin
                            n_out_valid = 1'b1;
                            n_out = '{task_slot: r_pend_slot, task_due: 1'b1,
                                      create_failed: 1'b0, last_of_run: 1'b0};
                        end
                        n_pend      = 1'b1;
                        n_pend_slot = 3'(r_p_idx);
                        n_cnt       = r_cnt + 1'b1;
                    end
                end else if (r_rd_idx == CW'(NUM_SLOTS)) begin
                    n_out_valid = 1'b1;
                    n_out = '{task_slot: r_pend ? r_pend_slot : 3'd0, task_due: r_pend,
                              create_failed: 1'b0, last_of_run: 1'b1};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_act       <= '0;
            r_rd_idx    <= '0;
            r_pv        <= 1'b0;
            r_p_idx     <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_pend_slot <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_act       <= n_act;
            r_rd_idx    <= n_rd_idx;
            r_pv        <= n_pv;
            r_p_idx     <= n_p_idx;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_pend_slot <= n_pend_slot;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== design/ptts_chk.sv =====
// ptts_chk: port-level checks for the scheduler core, bound to periodic_task_tick_scheduler_core.
// Uses ptts_pkg.

module ptts_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input ptts_pkg::t_req i_req,
    input logic           o_rsp_valid,
    input ptts_pkg::t_rsp o_rsp
);

    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.opcode != ptts_pkg::OP_TICK))
        |=> (o_rsp_valid && o_rsp.last_of_run && !o_rsp.task_due))
        else $error("non-tick request without single final result");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.opcode == ptts_pkg::OP_TICK)) |=> busy)
        else $error("tick request did not enter slot walk");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.task_due) |-> o_rsp.last_of_run)
        else $error("non-due result not marked last");

    a_fail_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.create_failed) |-> !o_rsp.task_due)
        else $error("create failure flagged on due result");

    a_open_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.last_of_run) |-> busy)
        else $error("open result run while idle");

endmodule

bind periodic_task_tick_scheduler_core ptts_chk u_ptts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

// ===== bench/tb_periodic_task_tick_scheduler_core.sv =====
// tb_periodic_task_tick_scheduler_core: self-checking bench for the tick scheduler core.
// Mirrors the slot table in a class, predicts every response per request, checks in order.
// Depends on ptts_pkg and periodic_task_tick_scheduler_core.
`timescale 1ns / 100ps

module tb_periodic_task_tick_scheduler_core;
    import ptts_pkg::*;

    localparam int SLOTS       = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 60;
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    class slot_table;
        bit          occupied[SLOTS];
        bit          active[SLOTS];
        logic [15:0] cnt[SLOTS];
        logic [15:0] reload[SLOTS];
        t_rsp        awaited[$];

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                occupied[i] = 1'b0;
                active[i]   = 1'b0;
                cnt[i]      = 16'd0;
                reload[i]   = 16'd0;
            end
        endfunction

        function void note_request(t_req r);
            t_rsp rsp;
            int   n;
            bit   in_range;
            in_range = int'(r.slot) < SLOTS;
            if (r.opcode == OP_TICK) begin
                n = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!active[i]) continue;
                    if (cnt[i] == 16'd0) begin
                        if (occupied[i]) begin
                            cnt[i] = reload[i] - 16'd1;
                            if (n < MAX_RESULTS) begin
                                rsp.task_slot     = 3'(i);
                                rsp.task_due      = 1'b1;
                                rsp.create_failed = 1'b0;
                                rsp.last_of_run   = 1'b0;
                                awaited.push_back(rsp);
                                n++;
                            end
                        end
                    end else begin
                        cnt[i] = cnt[i] - 16'd1;
                    end
                end
                if (n == 0) begin
                    rsp = '0;
                    rsp.last_of_run = 1'b1;
                end else begin
                    rsp = awaited.pop_back();
                    rsp.last_of_run = 1'b1;
                end
                awaited.push_back(rsp);
                return;
            end
            rsp = '0;
            rsp.task_slot   = r.slot;
            rsp.last_of_run = 1'b1;
            case (r.opcode)
                OP_CREATE: begin
                    if (!in_range || occupied[r.slot]) begin
                        rsp.create_failed = 1'b1;
                    end else begin
                        occupied[r.slot] = 1'b1;
                        active[r.slot]   = 1'b1;
                        reload[r.slot]   = r.period;
                        cnt[r.slot]      = r.first_delay;
                    end
                end
                OP_SUSPEND: if (in_range) active[r.slot] = 1'b0;
                OP_RESUME:  if (in_range) active[r.slot] = 1'b1;
                OP_DELETE:  if (in_range) occupied[r.slot] = 1'b0;
                default: ;
            endcase
            awaited.push_back(rsp);
        endfunction

        function string check_result(t_rsp got);
            t_rsp  want;
            string diff;
            if (awaited.size() == 0)
                return $sformatf("unexpected response slot %0d due %0b fail %0b last %0b",
                                 got.task_slot, got.task_due, got.create_failed,
                                 got.last_of_run);
            want = awaited.pop_front();
            diff = "";
            if (got.task_slot !== want.task_slot)
                diff = {diff, $sformatf(" task_slot %0d/%0d", got.task_slot, want.task_slot)};
            if (got.task_due !== want.task_due)
                diff = {diff, $sformatf(" task_due %0b/%0b", got.task_due, want.task_due)};
            if (got.create_failed !== want.create_failed)
                diff = {diff, $sformatf(" create_failed %0b/%0b", got.create_failed,
                                        want.create_failed)};
            if (got.last_of_run !== want.last_of_run)
                diff = {diff, $sformatf(" last_of_run %0b/%0b", got.last_of_run,
                                        want.last_of_run)};
            if (diff != "") diff = {"response mismatch (got/exp):", diff};
            return diff;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_rsp_valid;
    t_rsp o_rsp;

    slot_table tbl;
    string     mon_msg;
    int        errors;
    int        cycles;
    int        n_req, n_tick, n_rsp, n_due, n_refused;

    periodic_task_tick_scheduler_core #(
        .NUM_SLOTS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // responses are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid) begin
                n_rsp++;
                if (o_rsp.task_due) n_due++;
                if (o_rsp.create_failed) n_refused++;
                mon_msg = tbl.check_result(o_rsp);
                if (mon_msg != "") report_mismatch(mon_msg);
            end
            if (start && !busy) begin
                n_req++;
                if (i_req.opcode == OP_TICK) n_tick++;
                tbl.note_request(i_req);
            end
        end
    end

    function automatic t_req mk_req(logic [2:0] op, logic [2:0] s, logic [15:0] per,
                                    logic [15:0] fd);
        t_req r;
        r.opcode      = op;
        r.slot        = s;
        r.period      = per;
        r.first_delay = fd;
        return r;
    endfunction

    task automatic issue(input t_req r, input int idle_pct);
        int gap;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < MAX_GAP) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            i_req <= t_req'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tbl.awaited.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_req random_request();
        t_req        r;
        int          pick;
        int          s;
        logic [15:0] per;
        logic [15:0] fd;
        r    = t_req'({$urandom, $urandom});
        s    = $urandom_range(0, SLOTS - 1);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.opcode = OP_TICK;
        end else if (pick < 62) begin
            r.opcode = OP_CREATE;
            if ($urandom_range(0, 99) < 80) begin
                for (int i = 0; i < SLOTS; i++)
                    if (!tbl.occupied[(s + i) % SLOTS]) begin
                        s = (s + i) % SLOTS;
                        break;
                    end
            end
            case ($urandom_range(0, 6))
                0:       per = 16'd0;
                1:       per = 16'hFFFF;
                2:       per = 16'($urandom);
                default: per = 16'($urandom_range(1, 6));
            endcase
            fd = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8)) : 16'($urandom);
            r.period      = per;
            r.first_delay = fd;
        end else if (pick < 72) begin
            r.opcode = OP_SUSPEND;
        end else if (pick < 82) begin
            r.opcode = OP_RESUME;
        end else if (pick < 95) begin
            r.opcode = OP_DELETE;
        end else begin
            r.opcode = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        end
        r.slot = 3'(s);
        return r;
    endfunction

    initial begin
        int idle_mix[5];
        idle_mix = '{0, 87, 0, 16, 87};
        errors  = 0;
        cycles  = 0;
        n_req   = 0;
        n_tick  = 0;
        n_rsp   = 0;
        n_due   = 0;
        n_refused = 0;
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        tbl     = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(mk_req(OP_TICK, 3'd0, 16'd0, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd3, 16'hFFFF, 16'hFFFF), 0);
        issue(mk_req(OP_CREATE, 3'd3, 16'd5, 16'd0), 0);
        issue(mk_req(OP_DELETE, 3'd3, 16'd0, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd3, 16'd2, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd7, 16'd0, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd0, 16'd1, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd1, 16'd1, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd2, 16'd1, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd4, 16'd1, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd5, 16'd1, 16'd0), 0);
        issue(mk_req(OP_CREATE, 3'd6, 16'd1, 16'd0), 0);
        issue(mk_req(OP_TICK, 3'd0, 16'd0, 16'd0), 0);
        issue(mk_req(OP_TICK, 3'd0, 16'd0, 16'd0), 0);
        issue(mk_req(OP_SUSPEND, 3'd2, 16'd0, 16'd0), 0);
        issue(mk_req(OP_DELETE, 3'd5, 16'd0, 16'd0), 0);
        issue(mk_req(OP_TICK, 3'd0, 16'd0, 16'd0), 0);
        issue(mk_req(OP_RESUME, 3'd2, 16'd0, 16'd0), 0);
        issue(mk_req(OP_RSVD5, 3'd6, 16'hA5A5, 16'h5A5A), 0);
        issue(mk_req(OP_RSVD7, 3'd1, 16'hFFFF, 16'hFFFF), 0);
        issue(mk_req(OP_CREATE, 3'd5, 16'd3, 16'd1), 0);
        issue(mk_req(OP_TICK, 3'd0, 16'd0, 16'd0), 0);
        issue(mk_req(OP_TICK, 3'd0, 16'd0, 16'd0), 0);
        drain();

        foreach (idle_mix[p]) begin
            for (int k = 0; k < 86; k++) issue(random_request(), idle_mix[p]);
            if (p == 1) drain();
        end

        drain();
        repeat (SLOTS + 6) @(posedge i_clk);
        if (tbl.awaited.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", tbl.awaited.size()));
        $display("Coverage: %0d requests (%0d ticks), %0d responses in %0d cycles",
                 n_req, n_tick, n_rsp, cycles);
        $display("          %0d due reports, %0d refused creates, %0d mismatches",
                 n_due, n_refused, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
